// ===== src/ttw_pkg.sv =====
// Shared types, codes and helpers for the translation table walker.
// No dependencies; the walker modules import this package.
package ttw_pkg;

  typedef enum logic [1:0] {
    STATUS_READ  = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_FAULT = 2'd2,
    STATUS_IDLE  = 2'd3
  } status_t;

  // Descriptor type field, low two bits
  localparam logic [1:0] DESC_BLOCK = 2'b01;
  localparam logic [1:0] DESC_TABLE = 2'b11;

  typedef struct packed {
    logic              mode;
    logic [63:0]       root_base;
    logic [2:0]        start_level;
    logic [63:0]       virtual_address;
    logic [63:0]       descriptor;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [63:0]       read_address;
    logic signed [63:0] walk_result;
    logic [1:0]        walk_level;
  } out_item_t;

  // Byte offset of the descriptor for va in a table at level lvl
  function automatic logic [63:0] entry_offset(input logic [63:0] va, input logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return {52'd0, idx, 3'd0};
  endfunction

endpackage

// ===== src/ttw_if.sv =====
// Handshake channel interfaces for the translation table walker.
// Request, result and configuration channels; no dependencies.
interface ttw_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] root_base;
  logic [2:0]  start_level;
  logic [63:0] virtual_address;
  logic [63:0] descriptor;

  modport source (output valid, mode, root_base, start_level, virtual_address, descriptor,
                  input ready);
  modport sink (input valid, mode, root_base, start_level, virtual_address, descriptor,
                output ready);
endinterface

interface ttw_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [63:0]        read_address;
  logic signed [63:0] walk_result;
  logic [1:0]         walk_level;

  modport source (output valid, status, read_address, walk_result, walk_level, input ready);
  modport sink (input valid, status, read_address, walk_result, walk_level, output ready);
endinterface

interface ttw_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] phys_virt_offset;

  modport source (output valid, phys_virt_offset, input ready);
  modport sink (input valid, phys_virt_offset, output ready);
endinterface

// ===== src/translation_table_walker.sv =====
// Four-level 4 KB granule translation table walker, one word per step.
// Requests are held in the input register, results in the result register.
// Throughput: one request word per cycle unless an untaken result is held.
// Reset (rst, synchronous): walk idle, level and saved address zero,
// phys_virt_offset zero, both pipeline registers empty.
module translation_table_walker (
  input  logic      clk,
  input  logic      rst,
  ttw_req_if.sink   request,
  ttw_res_if.source result,
  ttw_cfg_if.sink   cfg
);
  import ttw_pkg::*;

  logic      item_vld;
  logic      free;
  logic      advance;
  in_item_t  item;
  out_item_t res;

  assign advance = item_vld && free;

  ttw_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  ttw_walk_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  ttw_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .res     (res),
    .free    (free),
    .result  (result)
  );

endmodule

// ===== src/ttw_in_stage.sv =====
// Input register: captures one request word per cycle unless stalled.
// Depends on ttw_pkg and ttw_req_if.
module ttw_in_stage (
  input  logic             clk,
  input  logic             rst,
  ttw_req_if.sink          request,
  input  logic             advance,
  output logic             item_vld,
  output ttw_pkg::in_item_t item
);
  import ttw_pkg::*;

  logic take;

  assign request.ready = !item_vld || advance;
  assign take = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (take) begin
      item_vld <= 1'b1;
    end else if (advance) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.mode            <= request.mode;
      item.root_base       <= request.root_base;
      item.start_level     <= request.start_level;
      item.virtual_address <= request.virtual_address;
      item.descriptor      <= request.descriptor;
    end
  end

  a_adv_needs_item: assert property (@(posedge clk) disable iff (rst)
    advance |-> item_vld)
    else $error("advance without a held word");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    item_vld && !advance |=> item_vld && $stable(item))
    else $error("held word changed while stalled");

  a_fill_on_take: assert property (@(posedge clk) disable iff (rst)
    take |=> item_vld)
    else $error("accepted word not held");

endmodule

// ===== src/ttw_walk_core.sv =====
// Walk state, offset register and descriptor classification.
// Depends on ttw_pkg and ttw_cfg_if.
module ttw_walk_core (
  input  logic              clk,
  input  logic              rst,
  ttw_cfg_if.sink           cfg,
  input  logic              advance,
  input  ttw_pkg::in_item_t item,
  output ttw_pkg::out_item_t res
);
  import ttw_pkg::*;

  logic        walk_active, walk_active_next;
  logic [1:0]  current_level, current_level_next;
  logic [63:0] saved_vaddr, saved_vaddr_next;
  logic [63:0] phys_virt_offset;
  logic [1:0]  next_level;
  logic [63:0] next_base;

  assign cfg.ready = 1'b1;

  assign next_level = current_level + 2'd1;
  assign next_base  = {16'd0, item.descriptor[47:12], 12'd0} - phys_virt_offset;

  always_comb begin
    res                = '0;
    res.status         = STATUS_IDLE;
    walk_active_next   = walk_active;
    current_level_next = current_level;
    saved_vaddr_next   = saved_vaddr;
    if (!item.mode) begin
      if (item.start_level[2]) begin
        walk_active_next = 1'b0;
        res.status       = STATUS_FAULT;
        res.walk_result  = -item.virtual_address;
      end else begin
        walk_active_next   = 1'b1;
        current_level_next = item.start_level[1:0];
        saved_vaddr_next   = item.virtual_address;
        res.status         = STATUS_READ;
        res.read_address   = item.root_base
                           + entry_offset(item.virtual_address, item.start_level[1:0]);
        res.walk_level     = item.start_level[1:0];
      end
    end else if (walk_active) begin
      res.walk_level = current_level;
      case (item.descriptor[1:0])
        DESC_BLOCK: begin
          walk_active_next = 1'b0;
          if (current_level == 2'd1) begin
            res.status      = STATUS_DONE;
            res.walk_result = {16'd0, item.descriptor[47:30], saved_vaddr[29:0]};
          end else if (current_level == 2'd2) begin
            res.status      = STATUS_DONE;
            res.walk_result = {16'd0, item.descriptor[47:21], saved_vaddr[20:0]};
          end else begin
            res.status      = STATUS_FAULT;
            res.walk_result = -saved_vaddr;
          end
        end
        DESC_TABLE: begin
          if (current_level == 2'd3) begin
            walk_active_next = 1'b0;
            res.status       = STATUS_DONE;
            res.walk_result  = {16'd0, item.descriptor[47:12], saved_vaddr[11:0]};
          end else begin
            current_level_next = next_level;
            res.status         = STATUS_READ;
            res.read_address   = next_base + entry_offset(saved_vaddr, next_level);
            res.walk_level     = next_level;
          end
        end
        default: begin
          walk_active_next = 1'b0;
          res.status       = STATUS_FAULT;
          res.walk_result  = -saved_vaddr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active      <= 1'b0;
      current_level    <= 2'd0;
      saved_vaddr      <= '0;
      phys_virt_offset <= '0;
    end else begin
      if (advance) begin
        walk_active   <= walk_active_next;
        current_level <= current_level_next;
        saved_vaddr   <= saved_vaddr_next;
      end
      if (cfg.valid && cfg.ready) begin
        phys_virt_offset <= cfg.phys_virt_offset;
      end
    end
  end

  a_bad_start_idles: assert property (@(posedge clk) disable iff (rst)
    advance && !item.mode && item.start_level[2] |=> !walk_active)
    else $error("walk left active after bad start level");

  a_table_steps_level: assert property (@(posedge clk) disable iff (rst)
    advance && item.mode && walk_active && res.status == STATUS_READ
    |=> current_level == 2'($past(current_level) + 2'd1))
    else $error("table descriptor did not advance the level");

  a_no_read_at_l3: assert property (@(posedge clk) disable iff (rst)
    advance && item.mode && current_level == 2'd3 |-> res.status != STATUS_READ)
    else $error("read requested beyond the last level");

  a_addr_only_on_read: assert property (@(posedge clk) disable iff (rst)
    res.status != STATUS_READ |-> res.read_address == '0)
    else $error("read address set on a non-read result");

endmodule

// ===== src/ttw_out_stage.sv =====
// Result register of the walker: holds one result word until taken.
// Depends on ttw_pkg and ttw_res_if.
module ttw_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  ttw_pkg::out_item_t res,
  output logic               free,
  ttw_res_if.source          result
);
  import ttw_pkg::*;

  logic      vld;
  out_item_t held;

  assign free = !vld || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= 1'b1;
    end else if (result.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= res;
    end
  end

  assign result.valid        = vld;
  assign result.status       = held.status;
  assign result.read_address = held.read_address;
  assign result.walk_result  = held.walk_result;
  assign result.walk_level   = held.walk_level;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance |-> free)
    else $error("result overwritten before taken");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> vld)
    else $error("loaded result not presented");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld && result.ready && !advance |=> !vld)
    else $error("taken result presented twice");

endmodule
